// ----- rtl/core/tsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants for the triangle span rasterizer core.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int CoordBits  = 12;
  localparam int SpanBits   = 11;
  localparam int LenBits    = 12;
  localparam int CfgBits    = 12;
  localparam int CfgIdxBits = 1;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = 1'b1;

  localparam logic [CfgBits-1:0] WidthReset  = 12'd240;
  localparam logic [CfgBits-1:0] HeightReset = 12'd320;
  localparam logic [CfgBits-1:0] WidthMax    = 12'd2048;

  // input operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  // edge selects: long edge v0-v2, top edge v0-v1, bottom edge v1-v2
  localparam logic [1:0] EdgeLong   = 2'd0;
  localparam logic [1:0] EdgeTop    = 2'd1;
  localparam logic [1:0] EdgeBottom = 2'd2;

  typedef struct packed {
    logic                        op;
    logic signed [CoordBits-1:0] x_a;
    logic signed [CoordBits-1:0] y_a;
    logic signed [CoordBits-1:0] x_b;
    logic signed [CoordBits-1:0] y_b;
    logic signed [CoordBits-1:0] x_c;
    logic signed [CoordBits-1:0] y_c;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] row;
    logic [SpanBits-1:0]         span_start;
    logic [LenBits-1:0]          span_length;
    logic                        drawn;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_store;
    logic [1:0] edge_sel;
    logic       round;
    logic       emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flat;
    logic active;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/tsr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_div
// Restoring divider, one quotient bit per cycle, with sign applied at the end.
// ----------------------------------------------------------------------------
module tsr_div #(
  parameter int NUM_BITS = 28,
  parameter int DEN_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [NUM_BITS-1:0]        num,
  input  wire logic [DEN_BITS-1:0]        den,
  input  wire logic                       neg,
  output logic                            done,
  output logic signed [NUM_BITS:0]        quo
);

  localparam int CntBits = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] num_r;
  logic [NUM_BITS-1:0] quo_r;
  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] den_r;
  logic [CntBits-1:0]  cnt_r;
  logic                run_r;
  logic                done_r;
  logic                neg_r;

  logic [DEN_BITS:0]   trial;
  logic                fits;
  logic [DEN_BITS:0]   diff;
  logic [NUM_BITS:0]   mag;

  assign trial = {rem_r, num_r[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign mag   = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CntBits'(NUM_BITS);
    end else if (run_r) begin
      cnt_r  <= cnt_r - CntBits'(1);
      run_r  <= (cnt_r != CntBits'(1));
      done_r <= (cnt_r == CntBits'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      neg_r <= neg;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[NUM_BITS-2:0], 1'b0};
      quo_r <= {quo_r[NUM_BITS-2:0], fits};
      rem_r <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? $signed(-mag) : $signed(mag);

endmodule
`default_nettype wire

// ----- rtl/core/tsr_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_dp
// Datapath: vertex sort, slope registers, edge walkers, span rounding and
// clamping, configuration registers and the result register.
// ----------------------------------------------------------------------------
module tsr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tsr_pkg::in_item_t                     in_data,
  input  wire tsr_pkg::ctrl_cmd_t                    cmd,
  input  wire logic                                  cfg_valid,
  input  wire logic [tsr_pkg::CfgIdxBits-1:0]        cfg_index,
  input  wire logic [tsr_pkg::CfgBits-1:0]           cfg_data,
  input  wire logic                                  out_stall,
  output logic                                       out_valid,
  output tsr_pkg::out_item_t                         out_data,
  output tsr_pkg::dp_status_t                        st
);

  localparam int CB        = tsr_pkg::CoordBits;
  localparam int SB        = tsr_pkg::SpanBits;
  localparam int LB        = tsr_pkg::LenBits;
  localparam int PosBits   = CB + 2 + FRAC_BITS;
  localparam int SlopeBits = CB + 1 + FRAC_BITS;
  localparam int EndBits   = CB + 2;
  localparam int NumBits   = CB + FRAC_BITS;
  localparam logic signed [PosBits-1:0] Half = PosBits'(1) << (FRAC_BITS - 1);

  logic signed [CB-1:0]        vx_r [3];
  logic signed [CB-1:0]        vy_r [3];
  logic signed [SlopeBits-1:0] slope_r [3];
  logic signed [PosBits-1:0]   long_r;
  logic signed [PosBits-1:0]   short_r;
  logic signed [CB-1:0]        row_r;
  logic                        bot_r;
  logic                        active_r;
  logic signed [EndBits-1:0]   end_a_r;
  logic signed [EndBits-1:0]   end_b_r;
  logic                        drawn_r;
  logic                        last_r;
  tsr_pkg::out_item_t          out_r;
  logic                        out_valid_r;
  logic [tsr_pkg::CfgBits-1:0] width_r;
  logic [tsr_pkg::CfgBits-1:0] height_r;

  // -- sort of the incoming vertices by row --
  logic signed [CB-1:0] sx [3];
  logic signed [CB-1:0] sy [3];

  always_comb begin
    logic signed [CB-1:0] tx;
    logic signed [CB-1:0] ty;
    tx = '0;
    ty = '0;
    sx[0] = in_data.x_a; sy[0] = in_data.y_a;
    sx[1] = in_data.x_b; sy[1] = in_data.y_b;
    sx[2] = in_data.x_c; sy[2] = in_data.y_c;
    if (sy[1] < sy[0]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[2] < sy[0]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[2]; sy[0] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[2] < sy[1]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
  end

  // -- divider operands for the selected edge --
  logic signed [CB:0]   dx;
  logic signed [CB:0]   dy;
  logic [CB:0]          dx_mag;
  logic [NumBits-1:0]   div_num;
  logic                 dy_zero;
  logic                 div_done;
  logic signed [SlopeBits-1:0] div_quo;

  always_comb begin
    unique case (cmd.edge_sel)
      tsr_pkg::EdgeLong: begin
        dx = {vx_r[2][CB-1], vx_r[2]} - {vx_r[0][CB-1], vx_r[0]};
        dy = {vy_r[2][CB-1], vy_r[2]} - {vy_r[0][CB-1], vy_r[0]};
      end
      tsr_pkg::EdgeTop: begin
        dx = {vx_r[1][CB-1], vx_r[1]} - {vx_r[0][CB-1], vx_r[0]};
        dy = {vy_r[1][CB-1], vy_r[1]} - {vy_r[0][CB-1], vy_r[0]};
      end
      tsr_pkg::EdgeBottom: begin
        dx = {vx_r[2][CB-1], vx_r[2]} - {vx_r[1][CB-1], vx_r[1]};
        dy = {vy_r[2][CB-1], vy_r[2]} - {vy_r[1][CB-1], vy_r[1]};
      end
      default: begin
        dx = '0;
        dy = '0;
      end
    endcase
    dx_mag  = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    div_num = {dx_mag[CB-1:0], {FRAC_BITS{1'b0}}};
    dy_zero = (dy == '0);
  end

  tsr_div #(
    .NUM_BITS (NumBits),
    .DEN_BITS (CB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (dy[CB-1:0]),
    .neg   (dx[CB]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // -- row setup: half switch and rounded edge ends --
  logic signed [PosBits-1:0] x1_pos;
  logic signed [PosBits-1:0] x0_pos;
  logic                      half_sw;
  logic signed [PosBits-1:0] short_eff;
  logic signed [PosBits-1:0] long_h;
  logic signed [PosBits-1:0] short_h;
  logic                      row_drawn;

  assign x0_pos    = {{2{sx[0][CB-1]}}, sx[0], {FRAC_BITS{1'b0}}};
  assign x1_pos    = {{2{vx_r[1][CB-1]}}, vx_r[1], {FRAC_BITS{1'b0}}};
  assign half_sw   = !bot_r && (row_r >= vy_r[1]);
  assign short_eff = half_sw ? x1_pos : short_r;
  assign long_h    = long_r + Half;
  assign short_h   = short_eff + Half;
  assign row_drawn = !row_r[CB-1] && ({1'b0, row_r[CB-2:0]} < height_r);

  // -- span ordering and clamping --
  function automatic logic [SB-1:0] clamp_end(input logic signed [EndBits-1:0] v,
                                               input logic [SB-1:0] lim);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({{(EndBits-SB){1'b0}}, lim})) begin
      return lim;
    end else begin
      return v[SB-1:0];
    end
  endfunction

  logic signed [EndBits-1:0] lo;
  logic signed [EndBits-1:0] hi;
  logic [tsr_pkg::CfgBits-1:0] wm1_full;
  logic [SB-1:0]             wm1;
  logic [SB-1:0]             clo;
  logic [SB-1:0]             chi;
  logic [LB-1:0]             len;

  always_comb begin
    lo = (end_a_r > end_b_r) ? end_b_r : end_a_r;
    hi = (end_a_r > end_b_r) ? end_a_r : end_b_r;
    priority if (width_r == '0) begin
      wm1_full = '0;
    end else if (width_r > tsr_pkg::WidthMax) begin
      wm1_full = tsr_pkg::WidthMax - tsr_pkg::CfgBits'(1);
    end else begin
      wm1_full = width_r - tsr_pkg::CfgBits'(1);
    end
    wm1 = wm1_full[SB-1:0];
    clo = clamp_end(lo, wm1);
    chi = clamp_end(hi, wm1);
    len = LB'(chi) - LB'(clo) + LB'(1);
  end

  // -- configuration --
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tsr_pkg::WidthReset;
      height_r <= tsr_pkg::HeightReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsr_pkg::RegScreenWidth:  width_r  <= cfg_data;
        tsr_pkg::RegScreenHeight: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // -- control flags --
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      bot_r    <= 1'b0;
    end else if (cmd.load) begin
      active_r <= !st.flat;
      bot_r    <= 1'b0;
    end else if (cmd.round) begin
      bot_r    <= bot_r || half_sw;
    end else if (cmd.emit && last_r) begin
      active_r <= 1'b0;
    end
  end

  // -- triangle and edge state --
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= sx[i];
        vy_r[i] <= sy[i];
      end
      long_r  <= x0_pos;
      short_r <= x0_pos;
      row_r   <= sy[0];
    end
    if (cmd.div_store) begin
      slope_r[cmd.edge_sel] <= dy_zero ? '0 : div_quo;
    end
    if (cmd.round) begin
      short_r <= short_eff;
      end_a_r <= $signed(long_h[PosBits-1:FRAC_BITS]);
      end_b_r <= $signed(short_h[PosBits-1:FRAC_BITS]);
      drawn_r <= row_drawn;
      last_r  <= row_r >= vy_r[2];
    end
    if (cmd.emit) begin
      long_r  <= long_r + {slope_r[0][SlopeBits-1], slope_r[0]};
      short_r <= short_r + (bot_r ? {slope_r[2][SlopeBits-1], slope_r[2]}
                                  : {slope_r[1][SlopeBits-1], slope_r[1]});
      row_r   <= row_r + CB'(1);
    end
  end

  // -- result register --
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.row         <= row_r;
      out_r.span_start  <= drawn_r ? clo : '0;
      out_r.span_length <= drawn_r ? len : '0;
      out_r.drawn       <= drawn_r;
      out_r.last        <= last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign st.flat     = (in_data.y_a == in_data.y_b) && (in_data.y_b == in_data.y_c);
  assign st.active   = active_r;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

// ----- rtl/core/tsr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_ctrl
// Controller: accepts items, sequences the three slope divisions on a
// non-flat load and the round / emit steps of a row.
// ----------------------------------------------------------------------------
module tsr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  input  wire tsr_pkg::dp_status_t st,
  output logic                     in_stall,
  output tsr_pkg::ctrl_cmd_t       cmd
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDivGo   = 3'd1;
  localparam logic [2:0] StDivWait = 3'd2;
  localparam logic [2:0] StRound   = 3'd3;
  localparam logic [2:0] StEmit    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] edge_r;
  logic [1:0] edge_nxt;
  logic       accept;

  assign accept = in_valid && (state_r == StIdle);

  always_comb begin
    state_nxt     = state_r;
    edge_nxt      = edge_r;
    cmd           = '0;
    cmd.edge_sel  = edge_r;
    unique case (state_r)
      StIdle: begin
        if (accept) begin
          if (in_op == tsr_pkg::OpLoad) begin
            cmd.load = 1'b1;
            edge_nxt = tsr_pkg::EdgeLong;
            if (!st.flat) begin
              state_nxt = StDivGo;
            end
          end else if (st.active) begin
            state_nxt = StRound;
          end
        end
      end
      StDivGo: begin
        cmd.div_start = 1'b1;
        state_nxt     = StDivWait;
      end
      StDivWait: begin
        if (st.div_done) begin
          cmd.div_store = 1'b1;
          if (edge_r == tsr_pkg::EdgeBottom) begin
            state_nxt = StIdle;
          end else begin
            edge_nxt  = edge_r + 2'd1;
            state_nxt = StDivGo;
          end
        end
      end
      StRound: begin
        cmd.round = 1'b1;
        state_nxt = StEmit;
      end
      StEmit: begin
        // hold until the result register can take the beat
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      edge_r  <= tsr_pkg::EdgeLong;
    end else begin
      state_r <= state_nxt;
      edge_r  <= edge_nxt;
    end
  end

  assign in_stall = (state_r != StIdle);

endmodule
`default_nettype wire

// ----- rtl/core/triangle_span_rasterizer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_span_rasterizer_core
// Scanline triangle fill: one load beat sets up a triangle, each step beat
// returns the span of the next row.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): op = load takes three
// vertices, sorts them by row and computes three Q.FRAC_BITS edge slopes; a
// load never gives a result. op = step gives one span beat on the output
// channel (out_valid / out_stall / out_data) while a triangle is active,
// from the top row to the bottom row, last set on the bottom row.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets screen
// width and height; write it only while the core is idle.
// Load: the three slopes are computed one after another by the shared
// one-bit-per-cycle slope divider. A flat triangle skips the divisions.
// Step: accept, round and emit, in that order, to the result register.
// While the receiver stalls, the result register holds; the core still takes
// the next beat and then waits in its emit cycle until the register frees.
// Reset (rst_n low, synchronous) clears the triangle, drops any pending
// result and restores width 240, height 320.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tsr_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tsr_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tsr_pkg::CfgIdxBits-1:0]    cfg_index,
  input  wire logic [tsr_pkg::CfgBits-1:0]       cfg_data
);

  tsr_pkg::ctrl_cmd_t  cmd;
  tsr_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  tsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tsr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

endmodule
`default_nettype wire

// ----- rtl/core/tsr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks for the triangle span rasterizer core.
// ----------------------------------------------------------------------------
module tsr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire tsr_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tsr_pkg::out_item_t out_data
);

  // a stalled result beat stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed under stall");

  // a load never produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == tsr_pkg::OpLoad) |=> !$rose(out_valid))
    else $error("result after a load beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drawn |-> (out_data.span_length == '0) &&
                                     (out_data.span_start == '0))
    else $error("undrawn row carries a span");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drawn |-> (out_data.span_length != '0))
    else $error("drawn row with empty span");

endmodule

bind triangle_span_rasterizer_core tsr_checker u_tsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ----- sim/tb_triangle_span_rasterizer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_triangle_span_rasterizer_core
// Self-checking bench for the triangle span rasterizer core. A span predictor
// tracks the sorted vertices, edge slopes and edge positions of the loaded
// triangle and queues the span each accepted step beat must produce; a monitor
// compares every output beat field by field against the oldest queued span.
// Stimulus runs directed corner triangles, random triangle sequences under
// several screen sizes, a long receiver hold-off and an unstalled tail.
// ----------------------------------------------------------------------------
module tb_triangle_span_rasterizer_core;

  localparam int FracBits     = 16;
  localparam int CoordBits    = tsr_pkg::CoordBits;
  localparam int SpanBits     = tsr_pkg::SpanBits;
  localparam int LenBits      = tsr_pkg::LenBits;
  localparam int CfgBits      = tsr_pkg::CfgBits;
  localparam int CfgIdxBits   = tsr_pkg::CfgIdxBits;
  localparam int InBits       = $bits(tsr_pkg::in_item_t);
  localparam int SettleCycles = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  tsr_pkg::in_item_t     in_data;
  logic                  out_valid;
  logic                  out_stall;
  tsr_pkg::out_item_t    out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [CfgBits-1:0]    cfg_data;

  triangle_span_rasterizer_core #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // span predictor state
  logic [CfgBits-1:0] screen_w;
  logic [CfgBits-1:0] screen_h;
  int                 vert_x[3];
  int                 vert_y[3];
  longint             edge_slope[3];
  longint             long_pos;
  longint             short_pos;
  int                 row_cur;
  bit                 lower_half;
  bit                 tri_live;

  tsr_pkg::out_item_t expected_spans[$];
  int        counted_beats;
  int        mismatch_count;
  bit        tx_gaps;
  bit        rx_gaps;
  int        rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #9000000;
    $display("FAIL triangle_span_rasterizer_core");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 40)
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic longint slope_q(input int dx, input int dy);
    if (dy == 0)
      return 0;
    return (longint'(dx) <<< FracBits) / longint'(dy);
  endfunction

  function automatic int clip_coord(input int v);
    if (v < -2048)
      return -2048;
    if (v > 2047)
      return 2047;
    return v;
  endfunction

  // Advance the predictor by one accepted beat; queue the span it causes.
  function automatic void predict_span(input tsr_pkg::in_item_t it);
    int        px[3];
    int        py[3];
    int        t;
    int        i;
    int        j;
    int        row;
    longint    a;
    longint    b;
    longint    w_eff;
    longint    half;
    tsr_pkg::out_item_t res;
    if (it.op == tsr_pkg::OpLoad) begin
      px[0] = int'($signed(it.x_a));
      py[0] = int'($signed(it.y_a));
      px[1] = int'($signed(it.x_b));
      py[1] = int'($signed(it.y_b));
      px[2] = int'($signed(it.x_c));
      py[2] = int'($signed(it.y_c));
      // pairwise swap on strictly smaller row, same order as the hardware sort
      for (i = 0; i < 2; i++) begin
        for (j = i + 1; j < 3; j++) begin
          if (py[j] < py[i]) begin
            t = px[i]; px[i] = px[j]; px[j] = t;
            t = py[i]; py[i] = py[j]; py[j] = t;
          end
        end
      end
      vert_x = px;
      vert_y = py;
      counted_beats++;
      if (py[0] == py[2]) begin
        tri_live = 1'b0;
        return;
      end
      edge_slope[tsr_pkg::EdgeLong]   = slope_q(px[2] - px[0], py[2] - py[0]);
      edge_slope[tsr_pkg::EdgeTop]    = slope_q(px[1] - px[0], py[1] - py[0]);
      edge_slope[tsr_pkg::EdgeBottom] = slope_q(px[2] - px[1], py[2] - py[1]);
      long_pos   = longint'(px[0]) <<< FracBits;
      short_pos  = long_pos;
      row_cur    = py[0];
      lower_half = 1'b0;
      tri_live   = 1'b1;
      return;
    end
    if (!tri_live)
      return;
    row   = row_cur;
    w_eff = longint'(screen_w);
    if (w_eff < 1)
      w_eff = 1;
    if (w_eff > 2048)
      w_eff = 2048;
    half = longint'(1) <<< (FracBits - 1);
    if (!lower_half && row >= vert_y[1]) begin
      lower_half = 1'b1;
      short_pos  = longint'(vert_x[1]) <<< FracBits;
    end
    res = '0;
    res.row = row[CoordBits-1:0];
    if (row >= 0 && row < int'(screen_h)) begin
      a = (long_pos + half) >>> FracBits;
      b = (short_pos + half) >>> FracBits;
      if (a > b) begin
        t = int'(a); a = b; b = longint'(t);
      end
      if (a < 0) a = 0;
      if (a > w_eff - 1) a = w_eff - 1;
      if (b < 0) b = 0;
      if (b > w_eff - 1) b = w_eff - 1;
      res.span_start  = SpanBits'(a);
      res.span_length = LenBits'(b - a + 1);
      res.drawn       = 1'b1;
    end
    res.last = (row >= vert_y[2]);
    expected_spans.push_back(res);
    counted_beats++;
    long_pos  += edge_slope[tsr_pkg::EdgeLong];
    short_pos += lower_half ? edge_slope[tsr_pkg::EdgeBottom] : edge_slope[tsr_pkg::EdgeTop];
    row_cur = row + 1;
    if (res.last)
      tri_live = 1'b0;
  endfunction

  // Offer one beat, hold it until accepted, then predict. Call at a clock edge.
  task automatic send_beat(input tsr_pkg::in_item_t it);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_span(it);
  endtask

  // Stop offering, drain every queued span and let a load finish its divides.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_screen(input logic [CfgBits-1:0] w, input logic [CfgBits-1:0] h);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= tsr_pkg::RegScreenWidth;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    screen_w = w;
    cfg_index <= tsr_pkg::RegScreenHeight;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    screen_h = h;
    cfg_valid <= 1'b0;
  endtask

  function automatic tsr_pkg::in_item_t load_of(input int xa, input int ya, input int xb,
                                                input int yb, input int xc, input int yc);
    tsr_pkg::in_item_t it;
    it.op  = tsr_pkg::OpLoad;
    it.x_a = xa[CoordBits-1:0];
    it.y_a = ya[CoordBits-1:0];
    it.x_b = xb[CoordBits-1:0];
    it.y_b = yb[CoordBits-1:0];
    it.x_c = xc[CoordBits-1:0];
    it.y_c = yc[CoordBits-1:0];
    return it;
  endfunction

  function automatic tsr_pkg::in_item_t noise_item();
    return tsr_pkg::in_item_t'(InBits'({$urandom, $urandom, $urandom}));
  endfunction

  function automatic tsr_pkg::in_item_t step_item();
    tsr_pkg::in_item_t it;
    it    = noise_item();
    it.op = tsr_pkg::OpStep;
    return it;
  endfunction

  // Triangle near the screen with a small row span, or with full-range fields.
  function automatic tsr_pkg::in_item_t random_load(input int max_rows, input bit full_x,
                                                    input bit full_y);
    int xs[3];
    int ys[3];
    int base;
    int wspan;
    int hspan;
    int k;
    wspan = (screen_w == 0) ? 1 : (screen_w > 2048 ? 2048 : int'(screen_w));
    hspan = (screen_h > 2047) ? 2047 : int'(screen_h);
    base  = int'($urandom_range(0, hspan + 16)) - 8;
    for (k = 0; k < 3; k++) begin
      ys[k] = full_y ? int'($urandom_range(0, 4095)) - 2048
                     : clip_coord(base + int'($urandom_range(0, max_rows)));
      xs[k] = full_x ? int'($urandom_range(0, 4095)) - 2048
                     : clip_coord(int'($urandom_range(0, wspan + 64)) - 32);
    end
    return load_of(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]);
  endfunction

  // Load, then step through the rows; now and then cut short or overrun.
  task automatic run_triangles(input int n_items, input int max_rows);
    int target;
    int cut;
    int n;
    bit full_y;
    target = counted_beats + n_items;
    while (counted_beats < target) begin
      if ($urandom_range(0, 15) == 0) begin
        send_beat(noise_item());
      end else begin
        full_y = ($urandom_range(0, 7) == 0);
        send_beat(random_load(($urandom_range(0, 29) == 0) ? 60 : max_rows,
                              $urandom_range(0, 3) == 0, full_y));
        cut = (full_y || $urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4)) : 1 << 30;
        n = 0;
        while (tri_live && n < cut) begin
          send_beat(step_item());
          n++;
        end
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) send_beat(step_item());
      end
    end
  endtask

  task automatic send_rows(input int n);
    repeat (n) send_beat(step_item());
  endtask

  task automatic test_directed_cases();
    // step with nothing loaded
    send_rows(1);
    // all rows equal, at the lowest row: dropped
    send_beat(load_of(3, -2048, 2047, -2048, -2048, -2048));
    send_rows(1);
    // columns at both extremes, clamped to the screen
    send_beat(load_of(-2048, 5, 2047, 6, 0, 7));
    send_rows(3);
    // rows above the screen
    send_beat(load_of(10, -2048, 20, -2046, 15, -2047));
    send_rows(3);
    // rows below the screen, up to the highest row
    send_beat(load_of(100, 2045, 2047, 2047, -5, 2046));
    send_rows(3);
    // flat top: tied rows, zero top slope, half switch on the first row
    send_beat(load_of(50, 10, 10, 10, 30, 13));
    send_rows(4);
    // a load replaces a triangle in progress
    send_beat(load_of(0, 0, 100, 40, 50, 80));
    send_rows(1);
    send_beat(load_of(200, 3, 180, 1, 239, 2));
    send_rows(3);
  endtask

  task automatic test_random_triangles();
    run_triangles(350, 12);
  endtask

  task automatic test_screen_extremes();
    set_screen(12'd1, 12'd1);
    run_triangles(60, 8);
    set_screen(tsr_pkg::WidthMax, tsr_pkg::WidthMax);
    run_triangles(60, 12);
    set_screen(12'd0, 12'd0);
    run_triangles(60, 8);
    set_screen(12'hFFF, 12'hFFF);
    run_triangles(60, 12);
    set_screen(CfgBits'($urandom_range(1, 2048)), CfgBits'($urandom_range(1, 2048)));
    run_triangles(60, 12);
    set_screen(tsr_pkg::WidthReset, tsr_pkg::HeightReset);
  endtask

  task automatic test_backpressure();
    // hold the receiver off while the sender keeps offering rows
    rx_hold_cycles = 400;
    send_beat(load_of(0, 0, 200, 75, 30, 149));
    send_rows(150);
    settle_idle();
    run_triangles(100, 12);
  endtask

  task automatic test_unstalled_tail();
    settle_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_triangles(150, 12);
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_spans
    tsr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("unexpected span beat, row", $signed(out_data.row), 0);
      end else begin
        want = expected_spans.pop_front();
        if (out_data.row !== want.row)
          report_mismatch("row", $signed(out_data.row), $signed(want.row));
        if (out_data.span_start !== want.span_start)
          report_mismatch("span_start", out_data.span_start, want.span_start);
        if (out_data.span_length !== want.span_length)
          report_mismatch("span_length", out_data.span_length, want.span_length);
        if (out_data.drawn !== want.drawn)
          report_mismatch("drawn", out_data.drawn, want.drawn);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tsr_pkg::RegScreenWidth;
    cfg_data  <= '0;
    screen_w       = tsr_pkg::WidthReset;
    screen_h       = tsr_pkg::HeightReset;
    vert_x         = '{0, 0, 0};
    vert_y         = '{0, 0, 0};
    edge_slope     = '{0, 0, 0};
    long_pos       = 0;
    short_pos      = 0;
    row_cur        = 0;
    lower_half     = 1'b0;
    tri_live       = 1'b0;
    counted_beats  = 0;
    mismatch_count = 0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    rx_hold_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_triangles();
    test_screen_extremes();
    test_backpressure();
    test_unstalled_tail();

    settle_idle();
    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("PASS triangle_span_rasterizer_core");
    end else begin
      $display("FAIL triangle_span_rasterizer_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
